FILE: sv/bfra_pkg.sv
// Shared types and constants for the best-fit range allocator.
// No dependencies; imported by bfra_div, bfra_cell and best_fit_range_allocator.
package bfra_pkg;

  localparam int HEAP_SLOTS      = 1024;
  localparam int MAX_FREE_BLOCKS = 512;
  localparam int STALE_DEPTH     = 256;

  localparam int START_W  = $clog2(HEAP_SLOTS);
  localparam int LEN_W    = $clog2(HEAP_SLOTS + 1);
  localparam int IDX_W    = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
  localparam int BLK_W    = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int PTR_W    = (STALE_DEPTH > 1) ? $clog2(STALE_DEPTH) : 1;
  localparam int FILL_W   = $clog2(STALE_DEPTH + 1);
  localparam int STAMP_W  = 16;
  localparam int STRIDE_W = 13;
  localparam int DATA_W   = 64;
  localparam int COUNT_W  = 11;
  localparam int REL_W    = 9;
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 4;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic REG_BASE   = 1'b0;
  localparam logic REG_STRIDE = 1'b1;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ALLOC_SCAN, ST_ALLOC_APPLY, ST_DIV, ST_FREE_APPLY,
    ST_REL_RD, ST_REL_CHK, ST_REL_SCAN, ST_REL_APPLY,
    ST_REN_LOAD, ST_REN_SHIFT, ST_REN_COMMIT, ST_RESP
  } state_e;

  // query broadcast to all cells during a scan
  typedef struct packed {
    logic [START_W-1:0] off;
    logic [LEN_W-1:0]   len;
  } qry_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic               best_v;
    logic [IDX_W-1:0]   best_idx;
    logic [START_W-1:0] best_start;
    logic [LEN_W-1:0]   best_len;
    logic [STAMP_W-1:0] best_stamp;
    logic               ovl;
    logic               prev_v;
    logic [IDX_W-1:0]   prev_idx;
    logic [LEN_W-1:0]   prev_len;
    logic               next_v;
    logic [IDX_W-1:0]   next_idx;
    logic [LEN_W-1:0]   next_len;
    logic               free_v;
    logic [IDX_W-1:0]   free_idx;
  } tok_t;

  // stamp circulating around the ring during renumbering
  typedef struct packed {
    logic               v;
    logic [STAMP_W-1:0] stamp;
  } ring_t;

  // update commands broadcast to the cells
  typedef struct packed {
    logic               wr_a;
    logic [IDX_W-1:0]   idx_a;
    logic [START_W-1:0] a_start;
    logic [LEN_W-1:0]   a_len;
    logic [STAMP_W-1:0] a_stamp;
    logic               clr_b;
    logic [IDX_W-1:0]   idx_b;
    logic               ring_load;
    logic               ring_shift;
    logic               rank_commit;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0]  frame;
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] off;
  } stale_t;

endpackage

FILE: sv/bfra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/bfra_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bfra_pkg.
module bfra_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [bfra_pkg::DATA_W-1:0]     dividend_i,
  input  logic [bfra_pkg::STRIDE_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [bfra_pkg::DATA_W-1:0]     quo_o
);
  import bfra_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [STRIDE_W-1:0]  rem_q, rem_d;
  logic [STRIDE_W:0]    shl;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    shl    = {rem_q, quo_q[DATA_W-1]};
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_STEPS);
      quo_d = dividend_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (shl >= {1'b0, divisor_i}) begin
        rem_d = STRIDE_W'(shl - {1'b0, divisor_i});
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = shl[STRIDE_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: sv/bfra_cell.sv
// One free-block cell: holds one block, refines the passing search record,
// and takes part in the stamp-ranking ring. Depends on bfra_pkg.
module bfra_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bfra_pkg::IDX_W-1:0]   idx_i,
  input  bfra_pkg::ctl_t               ctl_i,
  input  bfra_pkg::qry_t               qry_i,
  input  bfra_pkg::tok_t               tok_i,
  output bfra_pkg::tok_t               tok_o,
  input  bfra_pkg::ring_t              ring_i,
  output bfra_pkg::ring_t              ring_o
);
  import bfra_pkg::*;

  logic               valid_q, valid_d;
  logic [START_W-1:0] start_q, start_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [IDX_W:0]     rank_q, rank_d;
  ring_t              circ_q, circ_d;
  tok_t               tok_q, tok_d;
  logic [LEN_W:0]     blk_end, qry_end;

  // search step
  always_comb begin
    tok_d   = tok_i;
    blk_end = (LEN_W+1)'(start_q) + (LEN_W+1)'(len_q);
    qry_end = (LEN_W+1)'(qry_i.off) + (LEN_W+1)'(qry_i.len);
    if (valid_q) begin
      if (len_q >= qry_i.len &&
          (!tok_i.best_v || len_q < tok_i.best_len ||
           (len_q == tok_i.best_len && stamp_q < tok_i.best_stamp))) begin
        tok_d.best_v     = 1'b1;
        tok_d.best_idx   = idx_i;
        tok_d.best_start = start_q;
        tok_d.best_len   = len_q;
        tok_d.best_stamp = stamp_q;
      end
      if ((LEN_W+1)'(start_q) < qry_end && blk_end > (LEN_W+1)'(qry_i.off)) begin
        tok_d.ovl = 1'b1;
      end
      if (blk_end == (LEN_W+1)'(qry_i.off)) begin
        tok_d.prev_v   = 1'b1;
        tok_d.prev_idx = idx_i;
        tok_d.prev_len = len_q;
      end
      if ((LEN_W+1)'(start_q) == qry_end) begin
        tok_d.next_v   = 1'b1;
        tok_d.next_idx = idx_i;
        tok_d.next_len = len_q;
      end
    end else if (!tok_i.free_v) begin
      tok_d.free_v   = 1'b1;
      tok_d.free_idx = idx_i;
    end
  end

  // block updates and ranking
  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    len_d   = len_q;
    stamp_d = stamp_q;
    rank_d  = rank_q;
    circ_d  = circ_q;
    if (ctl_i.rank_commit && valid_q) begin
      stamp_d = STAMP_W'(rank_q);
    end
    if (ctl_i.wr_a && ctl_i.idx_a == idx_i) begin
      valid_d = 1'b1;
      start_d = ctl_i.a_start;
      len_d   = ctl_i.a_len;
      stamp_d = ctl_i.a_stamp;
    end
    if (ctl_i.clr_b && ctl_i.idx_b == idx_i) begin
      valid_d = 1'b0;
    end
    if (ctl_i.ring_load) begin
      circ_d = '{v: valid_q, stamp: stamp_q};
      rank_d = '0;
    end else if (ctl_i.ring_shift) begin
      if (circ_q.v && circ_q.stamp < stamp_q) begin
        rank_d = rank_q + 1'b1;
      end
      circ_d = ring_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= (idx_i == '0);
      start_q <= '0;
      len_q   <= LEN_W'(HEAP_SLOTS);
      stamp_q <= '0;
    end else begin
      valid_q <= valid_d;
      start_q <= start_d;
      len_q   <= len_d;
      stamp_q <= stamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    circ_q <= circ_d;
    tok_q  <= tok_d;
  end

  assign tok_o  = tok_q;
  assign ring_o = circ_q;

endmodule

FILE: sv/best_fit_range_allocator.sv
// Best-fit range allocator: controller, config port, stale queue, cell row.
// Depends on bfra_pkg, bfra_cell, bfra_div, bfra_ram.
// Allocate: one pass of the search record down the cell row. Free: waits on the
// bit-per-cycle divider. Release: one pass down the cell row per drained range.
// A stamp wrap adds a re-ranking pass around the stamp ring.
// One item at a time; output register lets the next item enter while a result waits.
// Reset (async, active low): one free block covering the heap, empty queue, stride 32.
module best_fit_range_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bfra_pkg::OP_W-1:0]      opcode_i,
  input  logic [bfra_pkg::COUNT_W-1:0]   count_i,
  input  logic [bfra_pkg::DATA_W-1:0]    handle_i,
  input  logic [bfra_pkg::DATA_W-1:0]    frame_number_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           ok_o,
  output logic [bfra_pkg::DATA_W-1:0]    out_handle_o,
  output logic [bfra_pkg::COUNT_W-1:0]   free_slots_o,
  output logic [bfra_pkg::REL_W-1:0]     released_ranges_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfra_pkg::ADDR_W-1:0]    paddr,
  input  logic [bfra_pkg::DATA_W-1:0]    pwdata,
  output logic [bfra_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import bfra_pkg::*;

  // ---------------- configuration ----------------
  logic [DATA_W-1:0]   base_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [STRIDE_W-1:0] stride_eff;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      stride_q <= STRIDE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_BASE:   base_q   <= pwdata;
        REG_STRIDE: stride_q <= pwdata[STRIDE_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_BASE:   prdata = base_q;
      REG_STRIDE: prdata = DATA_W'(stride_q);
      default:    prdata = '0;
    endcase
  end

  // a zero stride behaves as one
  assign stride_eff = (stride_q == '0) ? STRIDE_W'(1) : stride_q;

  // ---------------- state ----------------
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   cyc_q, cyc_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [DATA_W-1:0]  frame_q, frame_d;
  qry_t               qry_q, qry_d;
  logic [LEN_W-1:0]   free_total_q, free_total_d;
  logic [STAMP_W-1:0] next_stamp_q, next_stamp_d;
  logic [BLK_W-1:0]   blk_cnt_q, blk_cnt_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [REL_W-1:0]   rel_q, rel_d;
  logic               ok_q, ok_d;
  logic [DATA_W-1:0]  oh_q, oh_d;
  logic               ret_rel_q, ret_rel_d;   // renumbering returns to release loop
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q;
  logic [DATA_W-1:0]  out_oh_q;
  logic [COUNT_W-1:0] out_free_q;
  logic [REL_W-1:0]   out_rel_q;
  logic               out_load;

  // ---------------- cell row ----------------
  ctl_t  ctl;
  tok_t  tok_w  [MAX_FREE_BLOCKS+1];
  ring_t ring_w [MAX_FREE_BLOCKS];
  tok_t  tok_last;

  assign tok_w[0] = '0;
  assign tok_last = tok_w[MAX_FREE_BLOCKS];

  for (genvar g = 0; g < MAX_FREE_BLOCKS; g++) begin : g_cell
    bfra_cell u_cell (
      .clk_i,
      .rst_ni,
      .idx_i  (IDX_W'(g)),
      .ctl_i  (ctl),
      .qry_i  (qry_q),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1]),
      .ring_i (ring_w[(g + MAX_FREE_BLOCKS - 1) % MAX_FREE_BLOCKS]),
      .ring_o (ring_w[g])
    );
  end

  // ---------------- divider ----------------
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  bfra_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (handle_i - base_q),
    .divisor_i  (stride_eff),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // ---------------- stale queue ----------------
  logic             q_we;
  logic [PTR_W-1:0] q_tail;
  logic [PTR_W:0]   tail_sum;
  stale_t           q_wdata, q_rdata;

  assign tail_sum = (PTR_W+1)'(head_q) + (PTR_W+1)'(fill_q);
  assign q_tail   = (tail_sum >= (PTR_W+1)'(STALE_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W+1)'(STALE_DEPTH)) : PTR_W'(tail_sum);

  bfra_ram #(.WIDTH($bits(stale_t)), .DEPTH(STALE_DEPTH)) u_stale_ram (
    .clk_i,
    .we_i    (q_we),
    .waddr_i (q_tail),
    .wdata_i (q_wdata),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  // ---------------- decisions ----------------
  logic                        in_acc;
  logic [STAMP_W-1:0]          stamp_inc;
  logic                        stamp_wrap;
  logic                        alloc_exact;
  logic [START_W+1:0]          off_end;
  logic                        free_ok;
  logic                        rel_room;
  logic [PTR_W-1:0]            head_inc;
  logic                        last_cyc;
  logic [START_W+STRIDE_W-1:0] off_prod;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign stamp_inc  = next_stamp_q + 1'b1;
  assign stamp_wrap = (stamp_inc == '0);
  assign alloc_exact = (tok_last.best_len == cnt_q);
  // slot offset times stride, full product width
  assign off_prod   = (START_W+STRIDE_W)'(tok_last.best_start) *
                      (START_W+STRIDE_W)'(stride_eff);
  assign off_end    = (START_W+2)'(div_quo[START_W-1:0]) + (START_W+2)'(cnt_q);
  // nonzero count, offset in heap, range fits, queue has room
  assign free_ok    = (cnt_q != '0) && (div_quo[DATA_W-1:START_W] == '0) &&
                      (off_end <= (START_W+2)'(HEAP_SLOTS)) &&
                      (fill_q < FILL_W'(STALE_DEPTH));
  assign rel_room   = tok_last.prev_v || tok_last.next_v || tok_last.free_v;
  assign head_inc   = (head_q == PTR_W'(STALE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign last_cyc   = (cyc_q == IDX_W'(MAX_FREE_BLOCKS - 1));
  assign div_start  = in_acc && (opcode_i == OP_FREE);

  assign q_we    = (state_q == ST_FREE_APPLY) && free_ok;
  assign q_wdata = '{frame: frame_q, len: cnt_q, off: div_quo[START_W-1:0]};

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    cyc_d        = cyc_q;
    op_d         = op_q;
    cnt_d        = cnt_q;
    frame_d      = frame_q;
    qry_d        = qry_q;
    free_total_d = free_total_q;
    next_stamp_d = next_stamp_q;
    blk_cnt_d    = blk_cnt_q;
    head_d       = head_q;
    fill_d       = fill_q;
    rel_d        = rel_q;
    ok_d         = ok_q;
    oh_d         = oh_q;
    ret_rel_d    = ret_rel_q;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = opcode_i;
          cnt_d   = LEN_W'(count_i);
          frame_d = frame_number_i;
          ok_d    = 1'b0;
          oh_d    = '0;
          rel_d   = '0;
          qry_d   = '{off: '0, len: LEN_W'(count_i)};
          unique case (opcode_i)
            OP_ALLOC: begin
              if (count_i != '0 && LEN_W'(count_i) <= free_total_q) begin
                state_d = ST_ALLOC_SCAN;
              end else begin
                state_d = ST_RESP;
              end
            end
            OP_FREE:    state_d = ST_DIV;
            OP_RELEASE: state_d = ST_REL_RD;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_ALLOC_SCAN, ST_REL_SCAN: begin
        cyc_d = cyc_q + 1'b1;
        if (last_cyc) begin
          cyc_d   = '0;
          state_d = (state_q == ST_ALLOC_SCAN) ? ST_ALLOC_APPLY : ST_REL_APPLY;
        end
      end
      ST_ALLOC_APPLY: begin
        state_d = ST_RESP;
        if (tok_last.best_v) begin
          ok_d         = 1'b1;
          oh_d         = base_q + DATA_W'(off_prod);
          free_total_d = free_total_q - cnt_q;
          ret_rel_d    = 1'b0;
          if (alloc_exact) begin
            blk_cnt_d = blk_cnt_q - 1'b1;
          end else begin
            next_stamp_d = stamp_inc;
            if (stamp_wrap) state_d = ST_REN_LOAD;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_FREE_APPLY;
      end
      ST_FREE_APPLY: begin
        state_d = ST_RESP;
        if (free_ok) begin
          fill_d = fill_q + 1'b1;
          ok_d   = 1'b1;
        end
      end
      ST_REL_RD: begin
        // head entry shows on the RAM output after this cycle
        state_d = (fill_q == '0) ? ST_RESP : ST_REL_CHK;
        ok_d    = 1'b1;
      end
      ST_REL_CHK: begin
        if (q_rdata.frame > frame_q) begin
          state_d = ST_RESP;
        end else begin
          qry_d   = '{off: q_rdata.off, len: q_rdata.len};
          state_d = ST_REL_SCAN;
        end
      end
      ST_REL_APPLY: begin
        state_d = ST_REL_RD;
        if (tok_last.ovl) begin
          // double free: drop silently
          head_d = head_inc;
          fill_d = fill_q - 1'b1;
        end else if (!rel_room) begin
          state_d = ST_RESP;
        end else begin
          head_d       = head_inc;
          fill_d       = fill_q - 1'b1;
          rel_d        = rel_q + 1'b1;
          free_total_d = free_total_q + qry_q.len;
          next_stamp_d = stamp_inc;
          ret_rel_d    = 1'b1;
          if (tok_last.prev_v && tok_last.next_v) begin
            blk_cnt_d = blk_cnt_q - 1'b1;
          end else if (!tok_last.prev_v && !tok_last.next_v) begin
            blk_cnt_d = blk_cnt_q + 1'b1;
          end
          if (stamp_wrap) state_d = ST_REN_LOAD;
        end
      end
      ST_REN_LOAD: begin
        state_d = ST_REN_SHIFT;
      end
      ST_REN_SHIFT: begin
        cyc_d = cyc_q + 1'b1;
        if (last_cyc) begin
          cyc_d   = '0;
          state_d = ST_REN_COMMIT;
        end
      end
      ST_REN_COMMIT: begin
        next_stamp_d = STAMP_W'(blk_cnt_q);
        state_d      = ret_rel_q ? ST_REL_RD : ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // cell commands
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_ALLOC_APPLY: begin
        if (tok_last.best_v) begin
          if (alloc_exact) begin
            ctl.clr_b = 1'b1;
            ctl.idx_b = tok_last.best_idx;
          end else begin
            ctl.wr_a    = 1'b1;
            ctl.idx_a   = tok_last.best_idx;
            ctl.a_start = START_W'((START_W+1)'(tok_last.best_start) + (START_W+1)'(cnt_q));
            ctl.a_len   = tok_last.best_len - cnt_q;
            ctl.a_stamp = next_stamp_q;
          end
        end
      end
      ST_REL_APPLY: begin
        if (!tok_last.ovl) begin
          ctl.a_stamp = next_stamp_q;
          if (tok_last.prev_v) begin
            ctl.wr_a    = 1'b1;
            ctl.idx_a   = tok_last.prev_idx;
            ctl.a_start = START_W'(qry_q.off - tok_last.prev_len);
            ctl.a_len   = tok_last.prev_len + qry_q.len +
                          (tok_last.next_v ? tok_last.next_len : '0);
            ctl.clr_b   = tok_last.next_v;
            ctl.idx_b   = tok_last.next_idx;
          end else if (tok_last.next_v) begin
            ctl.wr_a    = 1'b1;
            ctl.idx_a   = tok_last.next_idx;
            ctl.a_start = qry_q.off;
            ctl.a_len   = qry_q.len + tok_last.next_len;
          end else if (tok_last.free_v) begin
            ctl.wr_a    = 1'b1;
            ctl.idx_a   = tok_last.free_idx;
            ctl.a_start = qry_q.off;
            ctl.a_len   = qry_q.len;
          end
        end
      end
      ST_REN_LOAD:   ctl.ring_load   = 1'b1;
      ST_REN_SHIFT:  ctl.ring_shift  = 1'b1;
      ST_REN_COMMIT: ctl.rank_commit = 1'b1;
      default:       ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cyc_q        <= '0;
      free_total_q <= LEN_W'(HEAP_SLOTS);
      next_stamp_q <= STAMP_W'(1);
      blk_cnt_q    <= BLK_W'(1);
      head_q       <= '0;
      fill_q       <= '0;
      ret_rel_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cyc_q        <= cyc_d;
      free_total_q <= free_total_d;
      next_stamp_q <= next_stamp_d;
      blk_cnt_q    <= blk_cnt_d;
      head_q       <= head_d;
      fill_q       <= fill_d;
      ret_rel_q    <= ret_rel_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cnt_q   <= cnt_d;
    frame_q <= frame_d;
    qry_q   <= qry_d;
    rel_q   <= rel_d;
    ok_q    <= ok_d;
    oh_q    <= oh_d;
    if (out_load) begin
      out_ok_q   <= ok_q && (op_q == OP_ALLOC || op_q == OP_FREE || op_q == OP_RELEASE);
      out_oh_q   <= oh_q;
      out_free_q <= COUNT_W'(free_total_q);
      out_rel_q  <= rel_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign out_handle_o      = out_oh_q;
  assign free_slots_o      = out_free_q;
  assign released_ranges_o = out_rel_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(STALE_DEPTH))
    else $error("stale queue fill beyond depth");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= LEN_W'(HEAP_SLOTS))
    else $error("free total beyond heap size");

  a_blk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_cnt_q <= BLK_W'(MAX_FREE_BLOCKS))
    else $error("block count beyond table size");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted item left controller idle");

  a_renum_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REN_COMMIT |=> next_stamp_q == STAMP_W'(blk_cnt_q))
    else $error("stamp counter not reset to block count after renumbering");
`endif

endmodule
